// ----- hdl/bmpg_pkg.sv -----
// Package for the BMP-to-grayscale decoder: transfer payload types, phase enum,
// status codes and header byte positions. No dependencies.
`default_nettype none
package bmpg_pkg;

    typedef struct packed {
        logic [7:0] file_byte;
        logic       end_of_file;
    } t_in_item;

    typedef struct packed {
        logic        pixel_valid;
        logic [11:0] pixel_row;
        logic [11:0] pixel_col;
        logic [7:0]  gray_level;
        logic        finished;
        logic [2:0]  status_code;
    } t_out_item;

    typedef enum logic [1:0] {
        PH_HEADER,
        PH_BODY,
        PH_DONE
    } t_phase;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_TOO_SMALL = 3'd1;
    localparam logic [2:0] ST_NOT_BMP   = 3'd2;
    localparam logic [2:0] ST_DIB       = 3'd3;
    localparam logic [2:0] ST_FORMAT    = 3'd4;
    localparam logic [2:0] ST_DIMS      = 3'd5;
    localparam logic [2:0] ST_OFFSET    = 3'd6;
    localparam logic [2:0] ST_TRUNC     = 3'd7;

    localparam int PALETTE_ENTRIES = 256;
    localparam int PAL_AW          = 8;
    localparam int PAL_CW          = 9;

    // byte positions (last byte of each little-endian header field)
    localparam logic [31:0] POS_SIG    = 32'd1;
    localparam logic [31:0] POS_OFFSET = 32'd13;
    localparam logic [31:0] POS_DIB    = 32'd17;
    localparam logic [31:0] POS_WIDTH  = 32'd21;
    localparam logic [31:0] POS_HEIGHT = 32'd25;
    localparam logic [31:0] POS_PLBPP  = 32'd29;
    localparam logic [31:0] POS_COMPR  = 32'd33;
    localparam logic [31:0] POS_HDREND = 32'd53;

    localparam logic [15:0] BMP_SIG  = 16'h4D42;
    localparam logic [31:0] MIN_DIB  = 32'd40;
    localparam logic [33:0] FILE_HDR = 34'd14;
    localparam logic [33:0] PAL_ENTRY_BYTES = 34'd4;

    localparam int ACC_W = 15;

endpackage
`default_nettype wire

// ----- hdl/bmp_to_gray_decoder_top.sv -----
// Top level of the BMP-to-grayscale stream decoder.
// Depends on bmpg_pkg and bmpg_luma.
`default_nettype none
// A BMP file streams in one byte per transfer. The 54-byte header is parsed as
// it passes and checked on its last byte; 8 bpp palette entries are turned into
// gray values and kept in a 256-entry memory; pixel bytes then yield one gray
// pixel with its top-down row and column, row padding being skipped. Each byte
// is registered together with the palette read it addresses, processed against
// the decoder state once the result register can take data, and the result
// lands in an output register, so a new byte is taken every cycle unless the
// output side stalls with a result still held. finished/status_code report the
// end of a file; end_of_file always returns the decoder to its reset state.
module bmp_to_gray_decoder_top #(
    parameter int MAX_WIDTH  = 4096,
    parameter int MAX_HEIGHT = 4096
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_valid,
    output logic                      o_in_stall,
    input  wire bmpg_pkg::t_in_item   i_in_data,
    output logic                      o_out_valid,
    input  wire logic                 i_out_stall,
    output bmpg_pkg::t_out_item       o_out_data
);
    import bmpg_pkg::*;

    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int HW = $clog2(MAX_HEIGHT + 1);

    // input stage
    logic       r_s0_v;
    logic [7:0] r_s0_byte;
    logic       r_s0_eof;
    logic [7:0] r_pal_rd;
    logic       in_take, out_free, adv;

    // decoder state
    t_phase           r_phase, n_phase;
    logic [31:0]      r_pos, n_pos;
    logic [31:0]      r_shift, n_shift;
    logic [31:0]      r_offset, n_offset;
    logic [31:0]      r_dib, n_dib;
    logic [31:0]      r_wraw, n_wraw;
    logic [31:0]      r_hraw, n_hraw;
    logic             r_sig_ok, n_sig_ok;
    logic             r_fmt_ok, n_fmt_ok;
    logic             r_tc, n_tc;
    logic             r_top, n_top;
    logic [WW-1:0]    r_width, n_width;
    logic [HW-1:0]    r_height, n_height;
    logic [PAL_CW-1:0] r_pcount, n_pcount;
    logic [ACC_W-1:0] r_acc, n_acc;
    logic [1:0]       r_bip, n_bip;
    logic [WW-1:0]    r_col, n_col;
    logic [HW-1:0]    r_row, n_row;
    logic [1:0]       r_pad, n_pad;

    logic [7:0] palette_mem [PALETTE_ENTRIES];

    // result register
    logic      r_out_v;
    t_out_item r_out;

    // datapath terms
    logic [33:0] pal_off, need;
    logic        before_px, pal_zone, pix_zone, done_px;
    logic [1:0]  lane;
    logic        pal_wr;
    logic [7:0]  luma_gray, px_gray;
    logic        last_col, last_row, img_end, hdr_last;
    logic [31:0] h_abs;
    logic        h_neg;
    logic [2:0]  hdr_st;
    t_phase      phase_pre;
    logic        fin;
    logic [2:0]  st;
    logic [31:0] col32, row32, w32;
    logic [HW-1:0] prow;
    logic [1:0]  raw_lo;
    t_out_item   res;

    // handshake: the byte stage moves whenever the result register can take data
    assign out_free   = !r_out_v || !i_out_stall;
    assign adv        = r_s0_v && out_free;
    assign o_in_stall = r_s0_v && !out_free;
    assign in_take    = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_v <= 1'b0;
        end else begin
            r_s0_v <= in_take || (r_s0_v && !out_free);
        end
        if (in_take) begin
            r_s0_byte <= i_in_data.file_byte;
            r_s0_eof  <= i_in_data.end_of_file;
        end
    end

    // palette memory: read with the byte address on transfer, written on entry's red byte
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_pal_rd <= palette_mem[i_in_data.file_byte];
        end
        if (adv && pal_wr) begin
            palette_mem[r_pcount[PAL_AW-1:0]] <= luma_gray;
        end
    end

    bmpg_luma u_luma (
        .i_acc  (r_acc),
        .i_red  (r_s0_byte),
        .o_gray (luma_gray)
    );

    // header check, evaluated on the last header byte
    assign h_neg = r_hraw[31];
    assign h_abs = h_neg ? (32'd0 - r_hraw) : r_hraw;
    assign need  = FILE_HDR + 34'(r_dib) + (r_tc ? 34'd0 : PAL_ENTRY_BYTES);

    always_comb begin
        if (!r_sig_ok) begin
            hdr_st = ST_NOT_BMP;
        end else if (r_dib < MIN_DIB) begin
            hdr_st = ST_DIB;
        end else if (!r_fmt_ok) begin
            hdr_st = ST_FORMAT;
        end else if (r_wraw == 32'd0 || r_wraw[31] || h_abs == 32'd0 || h_abs[31]
                     || r_wraw > 32'(MAX_WIDTH) || h_abs > 32'(MAX_HEIGHT)) begin
            hdr_st = ST_DIMS;
        end else if (34'(r_offset) < need) begin
            hdr_st = ST_OFFSET;
        end else begin
            hdr_st = ST_OK;
        end
    end

    // body classification
    assign pal_off   = FILE_HDR + 34'(r_dib);
    assign before_px = r_pos < r_offset;
    assign pal_zone  = (r_phase == PH_BODY) && before_px && !r_tc && (34'(r_pos) >= pal_off);
    assign lane      = r_pos[1:0] - pal_off[1:0];
    assign pal_wr    = pal_zone && (lane == 2'd2) && (r_pcount < PAL_CW'(PALETTE_ENTRIES));
    assign pix_zone  = (r_phase == PH_BODY) && !before_px && (r_pad == 2'd0);
    assign done_px   = pix_zone && (r_tc ? (r_bip == 2'd2) : 1'b1);
    assign last_col  = ((WW+1)'(r_col) + 1'b1) >= (WW+1)'(r_width);
    assign last_row  = ((HW+1)'(r_row) + 1'b1) >= (HW+1)'(r_height);
    assign img_end   = done_px && last_col && last_row;
    assign hdr_last  = (r_phase == PH_HEADER) && (r_pos == POS_HDREND);
    assign px_gray   = r_tc ? luma_gray
                     : (({1'b0, r_s0_byte} < r_pcount) ? r_pal_rd : r_s0_byte);

    // next phase
    always_comb begin
        phase_pre = r_phase;
        case (r_phase)
            PH_HEADER: begin
                if (hdr_last) begin
                    phase_pre = (hdr_st != ST_OK) ? PH_DONE : PH_BODY;
                end
            end
            PH_BODY: begin
                if (img_end) begin
                    phase_pre = PH_DONE;
                end
            end
            default: phase_pre = r_phase;
        endcase
        n_phase = r_s0_eof ? PH_HEADER : phase_pre;
    end

    // finish reporting
    always_comb begin
        fin = 1'b0;
        st  = ST_OK;
        if (hdr_last && hdr_st != ST_OK) begin
            fin = 1'b1;
            st  = hdr_st;
        end else if (img_end) begin
            fin = 1'b1;
            st  = ST_OK;
        end else if (r_s0_eof && phase_pre != PH_DONE) begin
            fin = 1'b1;
            if (phase_pre == PH_HEADER) begin
                st = ST_TOO_SMALL;
            end else begin
                st = before_px ? ST_OFFSET : ST_TRUNC;
            end
        end
    end

    // pixel coordinates and padding after a row
    assign prow   = r_top ? r_row : (r_height - HW'(1) - r_row);
    assign col32  = 32'(r_col);
    assign row32  = 32'(prow);
    assign w32    = 32'(r_width);
    assign raw_lo = r_tc ? 2'(w32[1:0] * 2'd3) : w32[1:0];

    always_comb begin
        res             = '0;
        res.finished    = fin;
        res.status_code = fin ? st : ST_OK;
        if (done_px) begin
            res.pixel_valid = 1'b1;
            res.pixel_row   = row32[11:0];
            res.pixel_col   = col32[11:0];
            res.gray_level  = px_gray;
        end
    end

    // state update
    always_comb begin
        n_pos    = (r_pos == 32'hFFFF_FFFF) ? r_pos : r_pos + 32'd1;
        n_shift  = r_shift;
        n_offset = r_offset;
        n_dib    = r_dib;
        n_wraw   = r_wraw;
        n_hraw   = r_hraw;
        n_sig_ok = r_sig_ok;
        n_fmt_ok = r_fmt_ok;
        n_tc     = r_tc;
        n_top    = r_top;
        n_width  = r_width;
        n_height = r_height;
        n_pcount = r_pcount;
        n_acc    = r_acc;
        n_bip    = r_bip;
        n_col    = r_col;
        n_row    = r_row;
        n_pad    = r_pad;

        if (r_phase == PH_HEADER) begin
            n_shift = {r_s0_byte, r_shift[31:8]};
            case (r_pos)
                POS_SIG:    n_sig_ok = (n_shift[31:16] == BMP_SIG);
                POS_OFFSET: n_offset = n_shift;
                POS_DIB:    n_dib    = n_shift;
                POS_WIDTH:  n_wraw   = n_shift;
                POS_HEIGHT: n_hraw   = n_shift;
                POS_PLBPP: begin
                    n_fmt_ok = (n_shift[15:0] == 16'd1)
                            && (n_shift[31:16] == 16'd8 || n_shift[31:16] == 16'd24);
                    n_tc     = (n_shift[31:16] == 16'd24);
                end
                POS_COMPR:  n_fmt_ok = r_fmt_ok && (n_shift == 32'd0);
                POS_HDREND: begin
                    n_width  = r_wraw[WW-1:0];
                    n_height = h_abs[HW-1:0];
                    n_top    = h_neg;
                end
                default: ;
            endcase
        end

        if (pal_zone) begin
            case (lane)
                2'd0: n_acc = ACC_W'(r_s0_byte) * ACC_W'(11);
                2'd1: n_acc = r_acc + ACC_W'(r_s0_byte) * ACC_W'(59);
                2'd3: begin
                    if (r_pcount < PAL_CW'(PALETTE_ENTRIES)) begin
                        n_pcount = r_pcount + 1'b1;
                    end
                end
                default: ;
            endcase
        end

        if ((r_phase == PH_BODY) && !before_px && (r_pad != 2'd0)) begin
            n_pad = r_pad - 2'd1;
        end

        if (pix_zone && r_tc) begin
            case (r_bip)
                2'd0: begin
                    n_acc = ACC_W'(r_s0_byte) * ACC_W'(11);
                    n_bip = 2'd1;
                end
                2'd1: begin
                    n_acc = r_acc + ACC_W'(r_s0_byte) * ACC_W'(59);
                    n_bip = 2'd2;
                end
                default: n_bip = 2'd0;
            endcase
        end

        if (done_px) begin
            n_col = r_col + WW'(1);
            if (last_col) begin
                n_col = '0;
                if (!last_row) begin
                    n_row = r_row + HW'(1);
                    n_pad = 2'd0 - raw_lo;
                end
            end
        end

        // end of file: back to the reset state for the next file
        if (r_s0_eof) begin
            n_pos    = '0;
            n_shift  = '0;
            n_offset = '0;
            n_dib    = '0;
            n_wraw   = '0;
            n_hraw   = '0;
            n_sig_ok = 1'b0;
            n_fmt_ok = 1'b0;
            n_tc     = 1'b0;
            n_top    = 1'b0;
            n_width  = '0;
            n_height = '0;
            n_pcount = '0;
            n_acc    = '0;
            n_bip    = '0;
            n_col    = '0;
            n_row    = '0;
            n_pad    = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_HEADER;
            r_pos    <= '0;
            r_shift  <= '0;
            r_offset <= '0;
            r_dib    <= '0;
            r_wraw   <= '0;
            r_hraw   <= '0;
            r_sig_ok <= 1'b0;
            r_fmt_ok <= 1'b0;
            r_tc     <= 1'b0;
            r_top    <= 1'b0;
            r_width  <= '0;
            r_height <= '0;
            r_pcount <= '0;
            r_acc    <= '0;
            r_bip    <= '0;
            r_col    <= '0;
            r_row    <= '0;
            r_pad    <= '0;
        end else if (adv) begin
            r_phase  <= n_phase;
            r_pos    <= n_pos;
            r_shift  <= n_shift;
            r_offset <= n_offset;
            r_dib    <= n_dib;
            r_wraw   <= n_wraw;
            r_hraw   <= n_hraw;
            r_sig_ok <= n_sig_ok;
            r_fmt_ok <= n_fmt_ok;
            r_tc     <= n_tc;
            r_top    <= n_top;
            r_width  <= n_width;
            r_height <= n_height;
            r_pcount <= n_pcount;
            r_acc    <= n_acc;
            r_bip    <= n_bip;
            r_col    <= n_col;
            r_row    <= n_row;
            r_pad    <= n_pad;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (adv) begin
            r_out_v <= done_px || fin;
        end else if (!i_out_stall) begin
            r_out_v <= 1'b0;
        end
        if (adv) begin
            r_out <= res;
        end
    end

    assign o_out_valid = r_out_v;
    assign o_out_data  = r_out;

endmodule
`default_nettype wire

// ----- hdl/bmpg_luma.sv -----
// Gray value from a weighted blue/green sum plus red: (30R+59G+11B)/100.
// Uses bmpg_pkg for the accumulator width.
`default_nettype none
module bmpg_luma (
    input  wire logic [bmpg_pkg::ACC_W-1:0] i_acc,
    input  wire logic [7:0]                 i_red,
    output logic [7:0]                      o_gray
);
    import bmpg_pkg::*;

    localparam logic [15:0] RECIP = 16'd41944;  // ceil(2^22/100), exact below 25600

    logic [ACC_W-1:0] sum;
    logic [30:0]      prod;

    assign sum    = i_acc + ACC_W'(i_red) * ACC_W'(30);
    assign prod   = 31'(sum) * 31'(RECIP);
    assign o_gray = prod[29:22];

endmodule
`default_nettype wire

// ----- tb/bmp_to_gray_decoder_top_tb.sv -----
// Self-checking testbench for bmp_to_gray_decoder_top: streams whole BMP files
// byte by byte and checks every result against a built-in decoder model.
// Depends on bmpg_pkg and the decoder RTL.
`default_nettype none
module bmp_to_gray_decoder_top_tb;
    import bmpg_pkg::*;

    // clock and reset
    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;
    always #5 i_clk = ~i_clk;

    // DUT ports; all inputs known from time zero
    logic      in_valid  = 1'b0;
    t_in_item  in_data   = '0;
    logic      out_stall = 1'b0;
    logic      in_stall;
    logic      out_valid;
    t_out_item out_data;

    bmp_to_gray_decoder_top DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data)
    );

    // run-wide bookkeeping
    t_out_item pending_pixels[$];   // expected results, oldest first
    int        mismatches = 0;
    bit        no_idle    = 1'b0;   // both sides stream without gaps
    int        hold_req   = 0;      // bumped by a test to request a long hold-off
    int        hold_seen  = 0;      // owned by the receiver process
    int        hold_cnt   = 0;
    logic [7:0] file_bytes[$];      // file under construction

    // ---------------------------------------------------------------
    // decoder model state
    // ---------------------------------------------------------------
    t_phase      m_phase;
    logic [31:0] m_pos, m_shift, m_pix_off, m_dib, m_width_raw, m_height_raw;
    logic [31:0] m_width, m_height, m_part, m_col, m_row, m_pad, m_bip, m_pal_cnt;
    logic        m_top, m_truecolor, m_sig_ok, m_fmt_ok;
    logic [7:0]  m_pal[PALETTE_ENTRIES];

    task clear_decoder();
        m_phase = PH_HEADER;
        m_pos = 0; m_shift = 0; m_pix_off = 0; m_dib = 0;
        m_width_raw = 0; m_height_raw = 0; m_width = 0; m_height = 0;
        m_part = 0; m_col = 0; m_row = 0; m_pad = 0; m_bip = 0; m_pal_cnt = 0;
        m_top = 0; m_truecolor = 0; m_sig_ok = 0; m_fmt_ok = 0;
    endtask

    // (30R + 59G + 11B) / 100
    function automatic logic [7:0] to_gray(logic [7:0] r, logic [7:0] g, logic [7:0] b);
        logic [31:0] sum;
        sum = r * 32'd30 + g * 32'd59 + b * 32'd11;
        return 8'(sum / 32'd100);
    endfunction

    // header verdict taken on its last byte
    task header_verdict(output logic [2:0] st);
        logic [31:0] h;
        logic [63:0] need;
        logic        top;
        top = m_height_raw[31];
        h   = top ? (32'd0 - m_height_raw) : m_height_raw;
        need = 64'd14 + m_dib + (m_truecolor ? 64'd0 : 64'd4);
        if (!m_sig_ok) st = ST_NOT_BMP;
        else if (m_dib < MIN_DIB) st = ST_DIB;
        else if (!m_fmt_ok) st = ST_FORMAT;
        else if (m_width_raw == 0 || m_width_raw[31]) st = ST_DIMS;
        else if (h == 0 || h[31]) st = ST_DIMS;
        else if (m_width_raw > 4096 || h > 4096) st = ST_DIMS;
        else if ({32'd0, m_pix_off} < need) st = ST_OFFSET;
        else begin
            st = ST_OK;
            m_width  = m_width_raw;
            m_height = h;
            m_top    = top;
        end
    endtask

    // advance the model by one accepted byte, queue the result it causes
    task decode_byte(input logic [7:0] b, input logic eof);
        logic [31:0] pos, lane, raw;
        logic [63:0] pal_off;
        logic        pv, fin, done_px;
        logic [2:0]  st;
        logic [31:0] prow, pcol;
        logic [7:0]  gray;
        t_out_item   res;
        pos = m_pos; pv = 0; fin = 0; st = ST_OK; prow = 0; pcol = 0; gray = 0;
        done_px = 0;
        if (m_phase == PH_HEADER) begin
            m_shift = {b, m_shift[31:8]};
            if (pos == POS_SIG) m_sig_ok = (m_shift[31:16] == BMP_SIG);
            else if (pos == POS_OFFSET) m_pix_off = m_shift;
            else if (pos == POS_DIB) m_dib = m_shift;
            else if (pos == POS_WIDTH) m_width_raw = m_shift;
            else if (pos == POS_HEIGHT) m_height_raw = m_shift;
            else if (pos == POS_PLBPP) begin
                m_fmt_ok = m_shift[15:0] == 16'd1 &&
                           (m_shift[31:16] == 16'd8 || m_shift[31:16] == 16'd24);
                m_truecolor = m_shift[31:16] == 16'd24;
            end else if (pos == POS_COMPR) begin
                m_fmt_ok = m_fmt_ok && m_shift == 0;
            end else if (pos == POS_HDREND) begin
                header_verdict(st);
                if (st != ST_OK) begin
                    fin = 1;
                    m_phase = PH_DONE;
                end else begin
                    m_phase = PH_BODY;
                end
            end
        end else if (m_phase == PH_BODY) begin
            pal_off = 64'd14 + m_dib;
            if (pos < m_pix_off) begin
                // palette region: BGRA entries, alpha byte commits the entry
                if (!m_truecolor && {32'd0, pos} >= pal_off) begin
                    lane = 32'(({32'd0, pos} - pal_off) & 64'd3);
                    if (lane == 0) m_part = b;
                    else if (lane == 1) m_part = m_part | (b << 8);
                    else if (lane == 2) begin
                        if (m_pal_cnt < PALETTE_ENTRIES)
                            m_pal[m_pal_cnt] = to_gray(b, m_part[15:8], m_part[7:0]);
                    end else if (m_pal_cnt < PALETTE_ENTRIES) begin
                        m_pal_cnt++;
                    end
                end
            end else if (m_pad > 0) begin
                m_pad--;
            end else begin
                if (m_truecolor) begin
                    if (m_bip == 0) begin m_part = b; m_bip = 1; end
                    else if (m_bip == 1) begin m_part = m_part | (b << 8); m_bip = 2; end
                    else begin
                        gray = to_gray(b, m_part[15:8], m_part[7:0]);
                        m_bip = 0;
                        done_px = 1;
                    end
                end else begin
                    // index past the palette passes through as its own gray
                    gray = (b < m_pal_cnt) ? m_pal[b] : b;
                    done_px = 1;
                end
                if (done_px) begin
                    pv = 1;
                    pcol = m_col;
                    prow = m_top ? m_row : (m_height - 1 - m_row);
                    m_col++;
                    if (m_col >= m_width) begin
                        raw = m_width * (m_truecolor ? 3 : 1);
                        m_col = 0;
                        if (m_row + 1 >= m_height) begin
                            fin = 1;
                            st = ST_OK;
                            m_phase = PH_DONE;
                        end else begin
                            m_row++;
                            m_pad = (32'd0 - raw) & 32'd3;
                        end
                    end
                end
            end
        end
        if (m_pos != 32'hFFFF_FFFF) m_pos++;
        if (eof) begin
            if (!fin && m_phase != PH_DONE) begin
                fin = 1;
                if (m_phase == PH_HEADER) st = ST_TOO_SMALL;
                else st = (pos < m_pix_off) ? ST_OFFSET : ST_TRUNC;
            end
            clear_decoder();
        end
        if (pv || fin) begin
            res.pixel_valid = pv;
            res.pixel_row   = pv ? prow[11:0] : 12'd0;
            res.pixel_col   = pv ? pcol[11:0] : 12'd0;
            res.gray_level  = pv ? gray : 8'd0;
            res.finished    = fin;
            res.status_code = fin ? st : ST_OK;
            pending_pixels = {pending_pixels, res};
        end
    endtask

    // ---------------------------------------------------------------
    // sender: one byte per transfer, random idle cycles ahead of it
    // ---------------------------------------------------------------
    task send_byte(input logic [7:0] b, input logic eof);
        while (!no_idle && $urandom_range(99) < 38) begin
            @(negedge i_clk);
            in_valid <= 1'b0;
        end
        @(negedge i_clk);
        in_valid <= 1'b1;
        in_data  <= '{file_byte: b, end_of_file: eof};
        @(posedge i_clk);
        while (in_stall) @(posedge i_clk);
        decode_byte(b, eof);
    endtask

    // sends file_bytes; end_of_file rides on the last byte
    task send_file();
        foreach (file_bytes[i])
            send_byte(file_bytes[i], i == file_bytes.size() - 1);
    endtask

    task add_byte(input logic [7:0] v);
        file_bytes = {file_bytes, v};
    endtask

    task put32(input logic [31:0] v);
        for (int i = 0; i < 4; i++) add_byte(v[8*i +: 8]);
    endtask

    // well-formed file layout; offset picks where the pixel data starts
    task build_file(input int bpp, input int w, input int h, input int dib,
                    input logic [31:0] offset, input bit last_pad);
        int rows, raw, pad;
        file_bytes.delete();
        add_byte("B");
        add_byte("M");
        put32($urandom);                 // file size, not checked
        put32($urandom);                 // reserved
        put32(offset);
        put32(dib);
        put32(w);
        put32(h);
        put32({16'(bpp), 16'd1});        // planes, then bits per pixel
        put32(32'd0);                    // no compression
        while (file_bytes.size() < 14 + dib) add_byte(8'($urandom));
        while (file_bytes.size() < offset) add_byte(8'($urandom));
        rows = (h < 0) ? -h : h;
        raw  = w * bpp / 8;
        pad  = (4 - raw % 4) % 4;
        for (int r = 0; r < rows; r++) begin
            repeat (raw) add_byte(8'($urandom));
            if (r < rows - 1 || last_pad) repeat (pad) add_byte(8'($urandom));
        end
    endtask

    // 8 bpp file with n palette entries and the usual 40-byte DIB
    task build_pal(input int w, input int h, input int n);
        build_file(8, w, h, 40, 54 + 4 * n, $urandom_range(1));
    endtask

    // ---------------------------------------------------------------
    // tests
    // ---------------------------------------------------------------
    task test_header_faults();
        // each header fault alone on an otherwise valid 24 bpp 2x2 file,
        // a few bytes kept past the header to be ignored
        for (int k = 0; k < 12; k++) begin
            build_file(24, 2, 2, 40, 54, 1);
            case (k)
                0:  file_bytes[1] = "X";                                  // signature
                1:  file_bytes[14] = 8'd39;                               // DIB too small
                2:  file_bytes[26] = 8'd2;                                // planes
                3:  file_bytes[28] = 8'd16;                               // bpp
                4:  file_bytes[30] = 8'd1;                                // compression
                5:  for (int i = 18; i < 22; i++) file_bytes[i] = 8'd0;   // zero width
                6:  file_bytes[21] = 8'h80;                               // negative width
                7:  for (int i = 22; i < 26; i++) file_bytes[i] = 8'd0;   // zero height
                8:  begin                                                 // height -2^31
                        for (int i = 22; i < 25; i++) file_bytes[i] = 8'd0;
                        file_bytes[25] = 8'h80;
                    end
                9:  begin file_bytes[18] = 8'h01; file_bytes[19] = 8'h10; end  // width 4097
                10: file_bytes[10] = 8'd53;                               // offset in header
                11: begin file_bytes[22] = 8'h01; file_bytes[23] = 8'h10; end  // height 4097
                default: ;
            endcase
            file_bytes = file_bytes[0:57];
            send_file();
        end
        // 8 bpp offset that leaves no room for a palette entry
        build_file(8, 1, 1, 40, 54, 1);
        send_file();
    endtask

    task test_early_end();
        build_file(24, 2, 2, 40, 54, 1);
        file_bytes = file_bytes[0:9];         // ends inside the header
        send_file();
        file_bytes = '{8'hFF};                // single-byte file
        send_file();
        build_pal(2, 2, 3);
        file_bytes = file_bytes[0:59];        // ends in the palette
        send_file();
        build_file(24, 3, 3, 40, 54, 1);
        file_bytes = file_bytes[0:70];        // ends mid-row
        send_file();
    endtask

    task test_layouts();
        build_file(24, 1, 1, 40, 54, 0);              // smallest picture
        send_file();
        build_file(24, 3, -2, 40, 54, 1);             // top-down rows
        send_file();
        build_file(24, 2, 2, 124, 14 + 124 + 5, 1);   // big DIB, slack before pixels
        send_file();
        build_pal(5, 3, 2);                           // indices past the palette
        send_file();
        build_pal(1, 1, 1);                           // junk after the last pixel
        repeat (7) add_byte(8'($urandom));
        send_file();
        build_pal(4096, 1, 1);                        // widest row, cut short
        file_bytes = file_bytes[0:69];
        send_file();
        build_pal(1, -4096, 1);                       // tallest, top-down, cut short
        file_bytes = file_bytes[0:69];
        send_file();
        build_pal(1, 4096, 1);                        // tallest, bottom-up, cut short
        file_bytes = file_bytes[0:69];
        send_file();
    endtask

    // mostly valid small files with random content, some faulted or cut short
    task test_random_files();
        int sent, kind, w, h, bpp, dib, n;
        logic [31:0] offset;
        sent = 0;
        while (sent < 300) begin
            bpp = $urandom_range(1) ? 24 : 8;
            w   = $urandom_range(6, 1);
            h   = $urandom_range(4, 1);
            if ($urandom_range(3) == 0) h = -h;
            dib = $urandom_range(3) == 0 ? $urandom_range(48, 40) : 40;
            n   = bpp == 8 ? $urandom_range(8, 1) : 0;
            offset = 14 + dib + 4 * n + ($urandom_range(2) == 0 ? $urandom_range(3) : 0);
            build_file(bpp, w, h, dib, offset, $urandom_range(1));
            kind = $urandom_range(9);
            if (kind == 0) file_bytes[$urandom_range(33)] = 8'($urandom);
            else if (kind == 1) file_bytes = file_bytes[0:$urandom_range(file_bytes.size() - 1)];
            else if (kind == 2) repeat ($urandom_range(4, 1)) add_byte(8'($urandom));
            send_file();
            sent += file_bytes.size();
        end
    endtask

    // receiver blocks for a long time while the sender keeps offering bytes
    task test_output_hold();
        hold_req++;
        build_file(24, 4, 2, 40, 54, 1);
        send_file();
    endtask

    // both sides streaming with no gaps at all
    task test_full_rate();
        no_idle = 1'b1;
        build_pal(3, 2, 2);
        send_file();
        build_file(24, 3, -2, 40, 54, 1);
        send_file();
        no_idle = 1'b0;
    endtask

    // ---------------------------------------------------------------
    // receiver stall: random, or a counted hold-off on request
    // ---------------------------------------------------------------
    always @(negedge i_clk) begin
        if (hold_seen != hold_req) begin
            hold_seen <= hold_req;
            hold_cnt  <= 300;
            out_stall <= 1'b1;
        end else if (hold_cnt > 0) begin
            hold_cnt  <= hold_cnt - 1;
            out_stall <= 1'b1;
        end else begin
            out_stall <= !no_idle && ($urandom_range(99) < 38);
        end
    end

    // ---------------------------------------------------------------
    // result checker: every transfer against the oldest expectation
    // ---------------------------------------------------------------
    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && out_valid && !out_stall) begin
            if (pending_pixels.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: %p", out_data);
            end else begin
                want = pending_pixels.pop_front();
                if (want.pixel_valid !== out_data.pixel_valid ||
                    want.pixel_row   !== out_data.pixel_row   ||
                    want.pixel_col   !== out_data.pixel_col   ||
                    want.gray_level  !== out_data.gray_level  ||
                    want.finished    !== out_data.finished    ||
                    want.status_code !== out_data.status_code) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected %p, got %p", want, out_data);
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // main sequence
    // ---------------------------------------------------------------
    initial begin
        int waited;
        clear_decoder();
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_header_faults();
        test_early_end();
        test_layouts();
        test_output_hold();
        test_full_rate();
        test_random_files();
        @(negedge i_clk);
        in_valid <= 1'b0;
        waited = 0;
        while (pending_pixels.size() > 0 && waited < 20000) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (10) @(posedge i_clk);
        if (pending_pixels.size() > 0) mismatches++;
        if (mismatches == 0) $display("CHECK OK");
        else $display("CHECK FAILED");
        $finish;
    end

    // hard stop well past the slowest legal run
    initial begin
        #5000000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule
`default_nettype wire
